>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vfm_pkg.sv
package vfm_pkg;

   // One face corner: offset from the voxel origin and the three
   // neighbour bits that darken it.
   typedef struct packed {
      logic       cx;
      logic       cy;
      logic       cz;
      logic [4:0] n0;
      logic [4:0] n1;
      logic [4:0] n2;
   } corner_type;

   // Classified voxel waiting for emission.
   typedef struct packed {
      logic [7:0]      pos_x;
      logic [3:0]      pos_y;
      logic [7:0]      pos_z;
      logic [7:0]      colour_index;
      logic [5:0]      faces;
      logic [5:0][5:0] occ;
   } qent_type;

   localparam int NUM_FACES  = 6;
   localparam int FACE_VERTS = 6;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   localparam logic [8:0] FULL_SHADE  = 9'd256;
   localparam logic [8:0] SHADE_RESET = 9'd179;

   // Neighbour bit index of offset (dx, dy, dz).
   function automatic logic [4:0] nb(input int dx, input int dy, input int dz);
      return 5'(dx + 1 + 3 * (dy + 1) + 9 * (dz + 1));
   endfunction

   function automatic corner_type cn(input logic cx, input logic cy, input logic cz,
                                     input logic [4:0] a, input logic [4:0] b,
                                     input logic [4:0] c);
      corner_type r;
      r.cx = cx;
      r.cy = cy;
      r.cz = cz;
      r.n0 = a;
      r.n1 = b;
      r.n2 = c;
      return r;
   endfunction

   // Facing neighbour per face, order +y, -y, +x, -x, -z, +z.
   localparam logic [4:0] FACING_TABLE [NUM_FACES] = '{
      nb(0, 1, 0), nb(0, -1, 0), nb(1, 0, 0), nb(-1, 0, 0), nb(0, 0, -1), nb(0, 0, 1)
   };

   // Corner order of the two triangles of each face.
   localparam corner_type CORNER_TABLE [NUM_FACES][FACE_VERTS] = '{
      // +y
      '{cn(0,1,0, nb(0,1,-1),  nb(-1,1,-1), nb(-1,1,0)),
        cn(0,1,1, nb(-1,1,0),  nb(-1,1,1),  nb(0,1,1)),
        cn(1,1,1, nb(0,1,1),   nb(1,1,1),   nb(1,1,0)),
        cn(0,1,0, nb(0,1,-1),  nb(-1,1,-1), nb(-1,1,0)),
        cn(1,1,1, nb(0,1,1),   nb(1,1,1),   nb(1,1,0)),
        cn(1,1,0, nb(0,1,-1),  nb(1,1,-1),  nb(1,1,0))},
      // -y
      '{cn(0,0,0, nb(0,-1,-1), nb(-1,-1,-1), nb(-1,-1,0)),
        cn(1,0,1, nb(0,-1,1),  nb(1,-1,1),   nb(1,-1,0)),
        cn(0,0,1, nb(-1,-1,0), nb(-1,-1,1),  nb(0,-1,1)),
        cn(0,0,0, nb(0,-1,-1), nb(-1,-1,-1), nb(-1,-1,0)),
        cn(1,0,0, nb(0,-1,-1), nb(1,-1,-1),  nb(1,-1,0)),
        cn(1,0,1, nb(0,-1,1),  nb(1,-1,1),   nb(1,-1,0))},
      // +x
      '{cn(1,0,0, nb(1,0,-1),  nb(1,-1,-1), nb(1,-1,0)),
        cn(1,1,0, nb(1,0,-1),  nb(1,1,-1),  nb(1,1,0)),
        cn(1,1,1, nb(1,1,0),   nb(1,1,1),   nb(1,0,1)),
        cn(1,0,0, nb(1,0,-1),  nb(1,-1,-1), nb(1,-1,0)),
        cn(1,1,1, nb(1,1,0),   nb(1,1,1),   nb(1,0,1)),
        cn(1,0,1, nb(1,0,1),   nb(1,-1,1),  nb(1,-1,0))},
      // -x
      '{cn(0,0,0, nb(-1,0,-1), nb(-1,-1,-1), nb(-1,-1,0)),
        cn(0,1,1, nb(-1,1,0),  nb(-1,1,1),   nb(-1,0,1)),
        cn(0,1,0, nb(-1,0,-1), nb(-1,1,-1),  nb(-1,1,0)),
        cn(0,0,0, nb(-1,0,-1), nb(-1,-1,-1), nb(-1,-1,0)),
        cn(0,0,1, nb(-1,0,1),  nb(-1,-1,1),  nb(-1,-1,0)),
        cn(0,1,1, nb(-1,1,0),  nb(-1,1,1),   nb(-1,0,1))},
      // -z
      '{cn(0,0,0, nb(-1,0,-1), nb(-1,-1,-1), nb(0,-1,-1)),
        cn(0,1,0, nb(-1,0,-1), nb(-1,1,-1),  nb(0,1,-1)),
        cn(1,1,0, nb(0,1,-1),  nb(1,1,-1),   nb(1,0,-1)),
        cn(0,0,0, nb(-1,0,-1), nb(-1,-1,-1), nb(0,-1,-1)),
        cn(1,1,0, nb(0,1,-1),  nb(1,1,-1),   nb(1,0,-1)),
        cn(1,0,0, nb(0,-1,-1), nb(1,-1,-1),  nb(1,0,-1))},
      // +z
      '{cn(0,0,1, nb(-1,0,1),  nb(-1,-1,1), nb(0,-1,1)),
        cn(1,1,1, nb(0,1,1),   nb(1,1,1),   nb(1,0,1)),
        cn(0,1,1, nb(-1,0,1),  nb(-1,1,1),  nb(0,1,1)),
        cn(0,0,1, nb(-1,0,1),  nb(-1,-1,1), nb(0,-1,1)),
        cn(1,0,1, nb(0,-1,1),  nb(1,-1,1),  nb(1,0,1)),
        cn(1,1,1, nb(0,1,1),   nb(1,1,1),   nb(1,0,1))}
   };

endpackage

>>> rtl/vfm_queue.sv
module vfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  vfm_pkg::qent_type wr_data,
   output logic              q_full,
   output logic              q_empty,
   input  logic              rd_en,
   output vfm_pkg::qent_type rd_data
);
   import vfm_pkg::*;

   qent_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   assign do_wr = wr_en && !q_full;
   assign do_rd = rd_en && !q_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/vfm_front.sv
module vfm_front #(
   parameter int CHUNK_EDGE      = 16,
   parameter int CHUNKS_PER_SIDE = 16
) (
   input  logic              push,
   input  logic              q_full,
   input  logic [7:0]        req_pos_x,
   input  logic [3:0]        req_pos_y,
   input  logic [7:0]        req_pos_z,
   input  logic [7:0]        req_block_kind,
   input  logic [26:0]       req_neighbour_mask,
   output logic              wr_en,
   output vfm_pkg::qent_type wr_data
);
   import vfm_pkg::*;

   localparam logic [16:0] EXTENT_W = 17'(CHUNK_EDGE * CHUNKS_PER_SIDE);
   localparam logic [8:0]  EDGE_W   = 9'(CHUNK_EDGE);

   logic       in_world;
   logic [5:0] faces;
   logic [5:0][5:0] occ;

   assign in_world = ({9'd0, req_pos_x} < EXTENT_W) &&
                     ({9'd0, req_pos_z} < EXTENT_W) &&
                     ({5'd0, req_pos_y} < EDGE_W);

   // Cull faces and mark darkened corners
   always_comb begin
      for (int f = 0; f < NUM_FACES; f++) begin
         faces[f] = !req_neighbour_mask[FACING_TABLE[f]];
         for (int v = 0; v < FACE_VERTS; v++) begin
            occ[f][v] = req_neighbour_mask[CORNER_TABLE[f][v].n0] ||
                        req_neighbour_mask[CORNER_TABLE[f][v].n1] ||
                        req_neighbour_mask[CORNER_TABLE[f][v].n2];
         end
      end
   end

   // Drop beats that yield no vertex
   assign wr_en = push && !q_full && (req_block_kind != 8'd0) && in_world &&
                  (faces != 6'd0);

   always_comb begin
      wr_data.pos_x        = req_pos_x;
      wr_data.pos_y        = req_pos_y;
      wr_data.pos_z        = req_pos_z;
      wr_data.colour_index = req_block_kind - 8'd1;
      wr_data.faces        = faces;
      wr_data.occ          = occ;
   end

endmodule

>>> rtl/vfm_back.sv
module vfm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [8:0]        csr_wdata,
   input  logic              q_empty,
   input  vfm_pkg::qent_type head,
   output logic              head_pop,
   output logic              empty,
   input  logic              pop,
   output logic [8:0]        rsp_corner_x,
   output logic [4:0]        rsp_corner_y,
   output logic [8:0]        rsp_corner_z,
   output logic [7:0]        rsp_colour_index,
   output logic [8:0]        rsp_shade,
   output logic              rsp_last_vertex
);
   import vfm_pkg::*;

   logic [8:0] shade_ff, shade_in;
   logic [5:0] done_ff, done_in;
   logic [2:0] vert_ff, vert_in;
   logic       out_valid_ff, out_valid_in;
   logic [8:0] out_x_ff, out_x_in;
   logic [4:0] out_y_ff, out_y_in;
   logic [8:0] out_z_ff, out_z_in;
   logic [7:0] out_colour_ff, out_colour_in;
   logic [8:0] out_shade_ff, out_shade_in;
   logic       out_last_ff, out_last_in;

   logic       advance, fire, face_end, item_end;
   logic [5:0] remaining, rem_after;
   logic [2:0] cur;
   corner_type corner;

   // Saturate the occluded shade at write time
   assign shade_in = (csr_wdata > FULL_SHADE) ? FULL_SHADE : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         shade_ff <= SHADE_RESET;
      end else if (csr_valid) begin
         shade_ff <= shade_in;
      end
   end

   // Pick the lowest face still to emit
   assign remaining = head.faces & ~done_ff;
   always_comb begin
      cur = 3'd0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            cur = 3'(i);
         end
      end
   end

   assign corner    = CORNER_TABLE[cur][vert_ff];
   assign rem_after = remaining & ~(6'd1 << cur);
   assign face_end  = (vert_ff == 3'(FACE_VERTS - 1));
   assign item_end  = face_end && (rem_after == 6'd0);

   assign advance  = !out_valid_ff || pop;
   assign fire     = advance && !q_empty;
   assign head_pop = fire && item_end;

   // Step through corners and load the output beat
   always_comb begin
      done_in       = done_ff;
      vert_in       = vert_ff;
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      out_colour_in = out_colour_ff;
      out_shade_in  = out_shade_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = !q_empty;
      end
      if (fire) begin
         out_x_in      = {1'b0, head.pos_x} + {8'd0, corner.cx};
         out_y_in      = {1'b0, head.pos_y} + {4'd0, corner.cy};
         out_z_in      = {1'b0, head.pos_z} + {8'd0, corner.cz};
         out_colour_in = head.colour_index;
         out_shade_in  = head.occ[cur][vert_ff] ? shade_ff : FULL_SHADE;
         out_last_in   = item_end;
         vert_in       = face_end ? 3'd0 : vert_ff + 3'd1;
         if (item_end) begin
            done_in = 6'd0;
         end else if (face_end) begin
            done_in = done_ff | (6'd1 << cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         vert_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         vert_ff      <= vert_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_colour_ff <= out_colour_in;
      out_shade_ff  <= out_shade_in;
      out_last_ff   <= out_last_in;
   end

   assign empty            = !out_valid_ff;
   assign rsp_corner_x     = out_x_ff;
   assign rsp_corner_y     = out_y_ff;
   assign rsp_corner_z     = out_z_ff;
   assign rsp_colour_index = out_colour_ff;
   assign rsp_shade        = out_shade_ff;
   assign rsp_last_vertex  = out_last_ff;

endmodule

>>> rtl/voxel_face_mesher_with_occlusion_core.sv
// Voxel face mesher with vertex ambient occlusion. Each voxel beat (position,
// block value, 27-bit solid mask of its neighbourhood) yields the vertices of
// its visible faces, six per face, faces in order +y, -y, +x, -x, -z, +z, with
// last_vertex set on the final one; empty, out-of-world or fully enclosed
// voxels yield nothing. Rate: the input takes one voxel per cycle until the
// four-entry classification queue fills; the output register emits one vertex
// per cycle while pop is held, and consecutive voxels follow without a gap.
// Culled voxels are dropped at the input. An accepted voxel is written into
// the queue, and its first vertex is then loaded into the output register.
// The occlusion shade register (reset 179, values above 256 read as 256) is
// written through the csr channel, which is always ready.
module voxel_face_mesher_with_occlusion_core #(
   parameter int CHUNK_EDGE      = 16,
   parameter int CHUNKS_PER_SIDE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_pos_x,
   input  logic [3:0]  req_pos_y,
   input  logic [7:0]  req_pos_z,
   input  logic [7:0]  req_block_kind,
   input  logic [26:0] req_neighbour_mask,
   output logic        empty,
   input  logic        pop,
   output logic [8:0]  rsp_corner_x,
   output logic [4:0]  rsp_corner_y,
   output logic [8:0]  rsp_corner_z,
   output logic [7:0]  rsp_colour_index,
   output logic [8:0]  rsp_shade,
   output logic        rsp_last_vertex,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);
   import vfm_pkg::*;

   logic     wr_en, q_full, q_empty, head_pop;
   qent_type wr_data, head;

   assign full      = q_full;
   assign csr_ready = 1'b1;

   vfm_front #(
      .CHUNK_EDGE      (CHUNK_EDGE),
      .CHUNKS_PER_SIDE (CHUNKS_PER_SIDE)
   ) u_front (
      .push               (push),
      .q_full             (q_full),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_block_kind     (req_block_kind),
      .req_neighbour_mask (req_neighbour_mask),
      .wr_en              (wr_en),
      .wr_data            (wr_data)
   );

   vfm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .q_full  (q_full),
      .q_empty (q_empty),
      .rd_en   (head_pop),
      .rd_data (head)
   );

   vfm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid && csr_ready),
      .csr_wdata        (csr_wdata),
      .q_empty          (q_empty),
      .head             (head),
      .head_pop         (head_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_corner_x     (rsp_corner_x),
      .rsp_corner_y     (rsp_corner_y),
      .rsp_corner_z     (rsp_corner_z),
      .rsp_colour_index (rsp_colour_index),
      .rsp_shade        (rsp_shade),
      .rsp_last_vertex  (rsp_last_vertex)
   );

endmodule

>>> rtl/vfm_checker.sv
`include "assert_macros.svh"

module vfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [8:0]  rsp_corner_x,
   input logic [4:0]  rsp_corner_y,
   input logic [8:0]  rsp_corner_z,
   input logic [7:0]  rsp_colour_index,
   input logic [8:0]  rsp_shade,
   input logic        rsp_last_vertex
);

   logic [40:0] rsp_beat;

   // Gather the whole result beat for the stability check
   assign rsp_beat = {rsp_corner_x, rsp_corner_y, rsp_corner_z, rsp_colour_index,
                      rsp_shade, rsp_last_vertex};

   // Hold a waiting beat until it is taken
   `VFM_ASSERT(a_rsp_hold, clock, reset, !empty && !pop |=> !empty && $stable(rsp_beat), "result beat changed while stalled")

   // Shade never exceeds full brightness
   `VFM_ASSERT(a_shade_range, clock, reset, !empty |-> rsp_shade <= 9'd256, "shade above full")

   // Corner height and colour stay in range
   `VFM_ASSERT(a_vertex_range, clock, reset, !empty |-> rsp_corner_y <= 5'd16 && rsp_colour_index != 8'd255, "vertex field out of range")

   // Output side is empty right after reset
   `VFM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> empty, "result pending after reset")

endmodule

bind voxel_face_mesher_with_occlusion_core vfm_checker u_checker (.*);
